// ----- sv/ode_pkg.sv -----
// Shared types and constants for the octahedral direction encoder.
package ode_pkg;

  localparam int unsigned QW         = 17;     // quotient bits, 0..65536
  localparam int unsigned DIV_STAGES = QW;     // one quotient bit per stage
  localparam logic [16:0] UNIT       = 17'd65536;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic       prec;
    logic [2:0] neg;   // component signs, bit 0 = x
  } ctrl_t;

endpackage

// ----- sv/ode_lane.sv -----
// Pipelined restoring divider: trunc(mag * 65536 / sum), one bit per stage.
module ode_lane (
  input  logic                      clk,
  input  logic [30:0]               mag,
  input  logic [30:0]               sum,
  output logic [ode_pkg::QW-1:0]    quot
);
  import ode_pkg::*;

  logic [31:0]   rem  [0:DIV_STAGES];
  logic [30:0]   dvs  [0:DIV_STAGES];
  logic [QW-1:0] qacc [0:DIV_STAGES];

  assign rem[0]  = {1'b0, mag};
  assign dvs[0]  = sum;
  assign qacc[0] = '0;

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [31:0] trial;
      logic        bit_q;
      // first stage holds the integer quotient bit (mag == sum)
      if (k == 0) begin : g_first
        assign trial = rem[k];
      end else begin : g_rest
        assign trial = {rem[k][30:0], 1'b0};
      end
      assign bit_q = (trial >= {1'b0, dvs[k]});
      always_ff @(posedge clk) begin
        rem[k+1]  <= bit_q ? (trial - {1'b0, dvs[k]}) : trial;
        dvs[k+1]  <= dvs[k];
        qacc[k+1] <= {qacc[k][QW-2:0], bit_q};
      end
    end
  endgenerate

  assign quot = qacc[DIV_STAGES];

endmodule

// ----- sv/ode_merge.sv -----
// Merge stage: hemisphere fold, quantization and packing, registered.
module ode_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  ode_pkg::ctrl_t         ctrl,
  input  logic [ode_pkg::QW-1:0] qx,
  input  logic [ode_pkg::QW-1:0] qy,
  input  logic [ode_pkg::QW-1:0] qz,
  output logic                   done,
  output logic [31:0]            packed_code,
  output logic                   encode_ok
);
  import ode_pkg::*;

  logic        fold, neg_u, neg_v;
  logic [16:0] mag_u, mag_v;
  logic [17:0] s_u, s_v;
  logic [15:0] q_u, q_v;
  logic [31:0] code_next;

  function automatic logic [15:0] quant(input logic [17:0] s, input logic prec);
    logic [34:0] p;
    if (prec) p = ({17'd0, s} << 16) - {17'd0, s} + 35'd65536;
    else      p = ({17'd0, s} << 8)  - {17'd0, s} + 35'd65536;
    return p[32:17];
  endfunction

  always_comb begin
    // sign of the truncated quotient, zero counts as plus
    neg_u = ctrl.neg[0] && (qx != '0);
    neg_v = ctrl.neg[1] && (qy != '0);
    fold  = ctrl.neg[2] && (qz != '0);
    mag_u = fold ? (UNIT - qy) : qx;
    mag_v = fold ? (UNIT - qx) : qy;
    s_u   = neg_u ? ({1'b0, UNIT} - {1'b0, mag_u}) : ({1'b0, UNIT} + {1'b0, mag_u});
    s_v   = neg_v ? ({1'b0, UNIT} - {1'b0, mag_v}) : ({1'b0, UNIT} + {1'b0, mag_v});
    q_u   = quant(s_u, ctrl.prec);
    q_v   = quant(s_v, ctrl.prec);
    if (!ctrl.ok)      code_next = '0;
    else if (ctrl.prec) code_next = {q_v, q_u};
    else               code_next = {16'd0, q_v[7:0], q_u[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    packed_code <= code_next;
    encode_ok   <= ctrl.ok;
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid && !ctrl.ok |=> packed_code == '0 && !encode_ok)
    else $error("rejected transaction produced nonzero code");

  a_narrow_high: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid && !ctrl.prec |=> packed_code[31:16] == '0)
    else $error("8-bit code has upper bits set");

  a_strobe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctrl.valid))
    else $error("strobe without a transaction in flight");

endmodule

// ----- sv/octahedral_direction_encoder.sv -----
// Top level: input check and L1 sum, three divider lanes, merge stage.
// Pipeline: an accepted start passes 1 sum stage, 17 divider stages and 1 merge
// stage before done. Throughput: one transaction per cycle; busy is low.
// The divider lanes retire one quotient bit per stage, which sets latency.
// Reset clears all pipeline valids and sets precision_mode to 8-bit.
module octahedral_direction_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        done,
  output logic [31:0] packed_code,
  output logic        encode_ok
);
  import ode_pkg::*;

  logic        precision_mode;
  logic [31:0] ax, ay, az;
  logic [32:0] sum_w;
  logic        any_min, ok_w;
  logic [30:0] mx, my, mz, sum_r;
  ctrl_t       ctrl [0:DIV_STAGES];
  ctrl_t       ctrl_next;
  logic [QW-1:0] qx, qy, qz;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision_mode <= 1'b0;
    end else if (cfg_we) begin
      precision_mode <= cfg_wdata;
    end
  end

  always_comb begin
    ax      = dir_x[31] ? (32'd0 - dir_x) : dir_x;
    ay      = dir_y[31] ? (32'd0 - dir_y) : dir_y;
    az      = dir_z[31] ? (32'd0 - dir_z) : dir_z;
    any_min = (dir_x == 32'h8000_0000) || (dir_y == 32'h8000_0000) ||
              (dir_z == 32'h8000_0000);
    sum_w   = {2'b0, ax[30:0]} + {2'b0, ay[30:0]} + {2'b0, az[30:0]};
    ok_w    = !any_min && (sum_w != '0) && (sum_w[32:31] == 2'b00);
    ctrl_next.valid = start && !busy;
    ctrl_next.ok    = ok_w;
    ctrl_next.prec  = precision_mode;
    ctrl_next.neg   = {dir_z[31], dir_y[31], dir_x[31]};
  end

  always_ff @(posedge clk) begin
    mx    <= ax[30:0];
    my    <= ay[30:0];
    mz    <= az[30:0];
    sum_r <= sum_w[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_STAGES; i++) ctrl[i] <= '0;
    end else begin
      ctrl[0] <= ctrl_next;
      for (int i = 1; i <= DIV_STAGES; i++) ctrl[i] <= ctrl[i-1];
    end
  end

  ode_lane u_lane_x (.clk(clk), .mag(mx), .sum(sum_r), .quot(qx));
  ode_lane u_lane_y (.clk(clk), .mag(my), .sum(sum_r), .quot(qy));
  ode_lane u_lane_z (.clk(clk), .mag(mz), .sum(sum_r), .quot(qz));

  ode_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl[DIV_STAGES]),
    .qx          (qx),
    .qy          (qy),
    .qz          (qz),
    .done        (done),
    .packed_code (packed_code),
    .encode_ok   (encode_ok)
  );

endmodule
